// ----- src/gvel_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvel_pkg
// Shared constants and types of the windowed gaze velocity core.
// ----------------------------------------------------------------------------
package gvel_pkg;

	localparam int MAX_HALF_DEF    = 8;
	localparam int COORD_WIDTH_DEF = 24;
	localparam int TRIAL_WIDTH_DEF = 16;

	localparam int WIN_W     = 5;
	localparam int RATE_W    = 12;
	localparam int VEL_W     = 32;
	localparam int CFG_ADDR_W = 8;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SAMPLES = 8'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_RATE_HZ = 8'd1;

	localparam logic [WIN_W-1:0]  WINDOW_SAMPLES_RST = 5'd5;
	localparam logic [RATE_W-1:0] SAMPLE_RATE_RST    = 12'd500;

	typedef struct packed {
		logic neg;
		logic vok;
		logic last;
	} gvel_side_t;

endpackage

// ----- src/gvel_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gvel_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module gvel_div #(
	parameter int NW  = 43,
	parameter int DDW = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic [NW-1:0]      in_num,
	input  logic [DDW-1:0]     in_den,
	input  gvel_pkg::gvel_side_t in_side,
	output logic               out_vld,
	output logic [NW-1:0]      out_quo,
	output gvel_pkg::gvel_side_t out_side
);

	logic                 vld_q  [NW];
	logic [NW-1:0]        num_q  [NW];
	logic [DDW-1:0]       den_q  [NW];
	logic [DDW-1:0]       rem_q  [NW];
	logic [NW-1:0]        quo_q  [NW];
	gvel_pkg::gvel_side_t side_q [NW];

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic                 vld_p;
		logic [NW-1:0]        num_p;
		logic [DDW-1:0]       den_p;
		logic [DDW-1:0]       rem_p;
		logic [NW-1:0]        quo_p;
		gvel_pkg::gvel_side_t side_p;
		logic [DDW:0]         rt;
		logic [DDW:0]         rs;
		logic                 ge;

		if (i == 0) begin : g_first
			assign vld_p  = in_vld;
			assign num_p  = in_num;
			assign den_p  = in_den;
			assign rem_p  = '0;
			assign quo_p  = '0;
			assign side_p = in_side;
		end else begin : g_next
			assign vld_p  = vld_q[i-1];
			assign num_p  = num_q[i-1];
			assign den_p  = den_q[i-1];
			assign rem_p  = rem_q[i-1];
			assign quo_p  = quo_q[i-1];
			assign side_p = side_q[i-1];
		end

		assign rt = {rem_p, num_p[NW-1]};
		assign rs = rt - {1'b0, den_p};
		assign ge = rt >= {1'b0, den_p};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else if (en) begin
				vld_q[i] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_q[i]  <= num_p << 1;
				den_q[i]  <= den_p;
				rem_q[i]  <= ge ? rs[DDW-1:0] : rt[DDW-1:0];
				quo_q[i]  <= {quo_p[NW-2:0], ge};
				side_q[i] <= side_p;
			end
		end
	end

	assign out_vld  = vld_q[NW-1];
	assign out_quo  = quo_q[NW-1];
	assign out_side = side_q[NW-1];

endmodule

// ----- src/windowed_gaze_velocity_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_gaze_velocity_core
// Windowed symmetric-difference velocity of a gaze coordinate stream.
//
// Input stream s_*: tdata holds sample_x and trial_id, tuser holds sample_ok,
// tlast marks the final sample of a stream. Output stream m_*: tdata holds the
// velocity, tuser velocity_ok, tlast the result of the stream's last sample.
// Config channel cfg_*: index 0 window_samples, 1 sample_rate_hz; write only
// while the core is idle. Unknown indexes are dropped.
// One sample is taken per cycle while s_tready is high. Each sample returns the
// velocity of the sample MAX_HALF positions back, once that position is filled.
// A tlast sample holds the input while the window drains its remaining centres,
// oldest first, then clears. Results pass the pair, sum, product and set-up
// registers, then the NW-bit divider, which resolves one quotient bit per stage.
// When a result waits on the output with m_tready low, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated. Reset empties the window and
// pipeline and loads the default window width (5) and rate (500 Hz).
// ----------------------------------------------------------------------------
module windowed_gaze_velocity_core #(
	parameter int MAX_HALF    = gvel_pkg::MAX_HALF_DEF,
	parameter int COORD_WIDTH = gvel_pkg::COORD_WIDTH_DEF,
	parameter int TRIAL_WIDTH = gvel_pkg::TRIAL_WIDTH_DEF,
	localparam int INW = ((COORD_WIDTH + TRIAL_WIDTH + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [INW-1:0]                  s_tdata,  // sample_x, trial_id
	input  logic                            s_tuser,  // sample_ok
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [gvel_pkg::VEL_W-1:0]      m_tdata,  // velocity
	output logic                            m_tuser,  // velocity_ok
	output logic                            m_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gvel_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [gvel_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int H     = MAX_HALF;
	localparam int DEPTH = 2 * H + 1;
	localparam int CW    = COORD_WIDTH;
	localparam int TW    = TRIAL_WIDTH;
	localparam int DW    = CW + 1;
	localparam int SW    = DW + $clog2(H + 1);
	localparam int WW    = $clog2(H * (H + 1) + 1);
	localparam int PW    = SW + gvel_pkg::RATE_W + 1;
	localparam int NW    = PW + 2;
	localparam int DDW   = WW + 1;
	localparam int EW    = (NW > 33) ? NW : 33;
	localparam int FCW   = $clog2(H + 1);

	logic [gvel_pkg::WIN_W-1:0]  ws_q;
	logic [gvel_pkg::RATE_W-1:0] rate_q;
	logic [gvel_pkg::WIN_W-1:0]  hmax;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q   <= gvel_pkg::WINDOW_SAMPLES_RST;
			rate_q <= gvel_pkg::SAMPLE_RATE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_addr)
				gvel_pkg::REG_WINDOW_SAMPLES: ws_q <= cfg_data[gvel_pkg::WIN_W-1:0];
				gvel_pkg::REG_SAMPLE_RATE_HZ: rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign hmax = (ws_q == '0) ? '0 : ((ws_q - 1'b1) >> 1);

	logic en, acc, step, clear;
	logic flush_q;
	logic [FCW-1:0] fcnt_q;
	logic out_vld_q;

	assign en       = !out_vld_q || m_tready;
	assign s_tready = en && !flush_q;
	assign acc      = s_tvalid && s_tready;
	assign step     = en && (acc || flush_q);
	assign clear    = flush_q && (fcnt_q == FCW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q <= 1'b0;
			fcnt_q  <= '0;
		end else if (step) begin
			if (acc && s_tlast) begin
				flush_q <= 1'b1;
				fcnt_q  <= FCW'(H);
			end else if (flush_q) begin
				fcnt_q <= fcnt_q - 1'b1;
				if (clear) begin
					flush_q <= 1'b0;
				end
			end
		end
	end

	logic signed [CW-1:0] win_x_q [DEPTH];
	logic [TW-1:0]        win_t_q [DEPTH];
	logic [DEPTH-1:0]     win_ok_q;
	logic [DEPTH-1:0]     win_p_q;
	logic signed [CW-1:0] nx_x [DEPTH];
	logic [TW-1:0]        nx_t [DEPTH];
	logic [DEPTH-1:0]     nx_ok;
	logic [DEPTH-1:0]     nx_p;

	always_comb begin
		nx_x[0]  = s_tdata[CW-1:0];
		nx_t[0]  = s_tdata[CW+TW-1:CW];
		nx_ok[0] = s_tuser;
		nx_p[0]  = acc;
		for (int k = 1; k < DEPTH; k++) begin
			nx_x[k]  = win_x_q[k-1];
			nx_t[k]  = win_t_q[k-1];
			nx_ok[k] = win_ok_q[k-1];
			nx_p[k]  = win_p_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_p_q <= '0;
		end else if (step) begin
			win_p_q <= clear ? '0 : nx_p;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			win_x_q  <= nx_x;
			win_t_q  <= nx_t;
			win_ok_q <= nx_ok;
		end
	end

	logic                 vld_s1, last_s1;
	logic signed [DW-1:0] diff_s1 [H];
	logic [H-1:0]         pok_s1;

	for (genvar i = 0; i < H; i++) begin : g_pair
		always_ff @(posedge clk) begin
			if (en) begin
				diff_s1[i] <= DW'(nx_x[H-i-1]) - DW'(nx_x[H+i+1]);
				pok_s1[i]  <= (6'(i + 1) <= {1'b0, hmax})
					&& nx_p[H-i-1] && nx_p[H+i+1]
					&& nx_ok[H-i-1] && nx_ok[H+i+1]
					&& (nx_t[H-i-1] == nx_t[H]) && (nx_t[H+i+1] == nx_t[H]);
			end
		end
	end

	logic signed [SW-1:0] sum_c, sum_s2;
	logic [WW-1:0]        wt_c, wt_s2, wt_s3;
	logic                 vld_s2, last_s2, vld_s3, last_s3;
	logic signed [PW-1:0] pa, pb, prod_s3;

	always_comb begin
		sum_c = '0;
		wt_c  = '0;
		for (int i = 0; i < H; i++) begin
			if (pok_s1[i]) begin
				sum_c = sum_c + SW'(diff_s1[i]);
				wt_c  = wt_c + WW'(2 * (i + 1));
			end
		end
	end

	assign pa = PW'(sum_s2);
	assign pb = PW'($signed({1'b0, rate_q}));

	logic [PW-1:0]        mag;
	logic                 vld_s4;
	logic [NW-1:0]        num_s4;
	logic [DDW-1:0]       den_s4;
	gvel_pkg::gvel_side_t side_s4;

	assign mag = prod_s3[PW-1] ? PW'(-prod_s3) : PW'(prod_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= step && nx_p[H];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1      <= clear;
			sum_s2       <= sum_c;
			wt_s2        <= wt_c;
			last_s2      <= last_s1;
			prod_s3      <= pa * pb;
			wt_s3        <= wt_s2;
			last_s3      <= last_s2;
			num_s4       <= NW'({mag, 1'b0}) + NW'(wt_s3);
			den_s4       <= {wt_s3, 1'b0};
			side_s4.neg  <= prod_s3[PW-1];
			side_s4.vok  <= wt_s3 != '0;
			side_s4.last <= last_s3;
		end
	end

	logic                 div_vld;
	logic [NW-1:0]        div_quo;
	gvel_pkg::gvel_side_t div_side;

	gvel_div #(
		.NW  (NW),
		.DDW (DDW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.in_num   (num_s4),
		.in_den   (den_s4),
		.in_side  (side_s4),
		.out_vld  (div_vld),
		.out_quo  (div_quo),
		.out_side (div_side)
	);

	logic [EW-1:0]                qe;
	logic [gvel_pkg::VEL_W-1:0]   vel_c, vel_q;
	logic                         vok_q, last_q;

	assign qe = EW'(div_quo);

	always_comb begin
		if (!div_side.vok) begin
			vel_c = '0;
		end else if (div_side.neg) begin
			vel_c = (qe > EW'(64'h8000_0000)) ? 32'h8000_0000 : -div_quo[31:0];
		end else begin
			vel_c = (qe > EW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_quo[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vel_q  <= vel_c;
			vok_q  <= div_side.vok;
			last_q <= div_side.last;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = vel_q;
	assign m_tuser  = vok_q;
	assign m_tlast  = last_q;

	a_no_take_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> !s_tready)
		else $error("input taken during flush");

	a_end_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input not held after stream end");

	a_final_no_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> !m_tuser)
		else $error("final result carries a pair");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("invalid velocity not zero");

endmodule
